[sv/modexp_pkg.sv]
// modexp_pkg: widths and constants shared by the modular exponentiation unit
package modexp_pkg;

   localparam int unsigned FIELD_W    = 31;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CNT_W      = $clog2(FIELD_W);

   localparam logic [FIELD_W-1:0] MODULUS_RESET = 31'd1000000007;

endpackage

[sv/modular_exponentiation_unit.sv]
// modular_exponentiation_unit: base^exponent mod modulus by square-and-multiply
//
//   channel | dir | beat contents (lowest bit first)
//   --------+-----+-------------------------------------------------------
//   req     | in  | tdata: base_value[30:0], exponent[61:31], zeros[63:62]
//   rsp     | out | tdata: power_result[30:0], zero[31]
//   csr     | in  | wdata: modulus[30:0], written when csr_wen is high
//
// one request at a time; a shared step (2r + addend, then up to two modulus
// subtracts) takes one multiplier bit per cycle through each modular product.
// the base is reduced first, then each exponent bit costs a multiply if set and
// a square if higher bits remain; a zero exponent, zero base or zero modulus goes
// straight to done; done waits while a result is unaccepted.
// reset is synchronous and restores the modulus to 1000000007.
module modular_exponentiation_unit #(
   parameter int unsigned EXP_BITS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // base_value[30:0], exponent[61:31], zero pad[63:62]
   input  logic [modexp_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // power_result[30:0], zero pad[31]
   output logic [modexp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                                csr_wen,
   input  logic [modexp_pkg::FIELD_W-1:0]      csr_wdata
);

   localparam int unsigned FW    = modexp_pkg::FIELD_W;
   localparam int unsigned CW    = modexp_pkg::CNT_W;
   localparam int unsigned EXP_W = (EXP_BITS < FW) ? EXP_BITS : FW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]      r_ff, r_in;
   logic [FW-1:0]      mplier_ff, mplier_in;
   logic [FW-1:0]      base_ff, base_in;
   logic [FW-1:0]      acc_ff, acc_in;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   logic [FW-1:0]      mod_ff, mod_in;
   logic [FW-1:0]      rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [FW-1:0]      req_base;
   logic [EXP_W-1:0]   req_exp;
   logic [EXP_W-1:0]   exp_shift;
   logic [FW-1:0]      addend;
   logic [FW+1:0]      sum;
   logic [FW+2:0]      diff1;
   logic [FW+2:0]      diff2;
   logic [FW-1:0]      unit_res;
   logic               last_step;

   assign req_base  = req_tdata[FW-1:0];
   assign req_exp   = req_tdata[FW +: EXP_W];
   assign exp_shift = exp_ff >> 1;
   assign last_step = (cnt_ff == CW'(FW - 1));

   // shared step: r <- (2r + addend) mod m, valid while r < m and addend < m
   always_comb begin
      addend = '0;
      if (mplier_ff[FW-1]) begin
         addend = (state_ff == ST_REDUCE) ? FW'(1) : base_ff;
      end
      sum   = {1'b0, r_ff, 1'b0} + {2'b00, addend};
      diff1 = {1'b0, sum} - {3'b000, mod_ff};
      diff2 = {1'b0, sum} - {2'b00, mod_ff, 1'b0};
      if (!diff2[FW+2]) begin
         unit_res = diff2[FW-1:0];
      end else if (!diff1[FW+2]) begin
         unit_res = diff1[FW-1:0];
      end else begin
         unit_res = sum[FW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      r_in         = r_ff;
      mplier_in    = mplier_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      mod_in       = csr_wen ? csr_wdata : mod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               exp_in    = req_exp;
               mplier_in = req_base;
               r_in      = '0;
               cnt_in    = '0;
               if (req_exp == '0) begin
                  acc_in   = FW'(1);
                  state_in = ST_DONE;
               end else if (req_base == '0 || mod_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  acc_in   = FW'(1);
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_MUL, ST_SQR: begin
            r_in      = unit_res;
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff + CW'(1);
            if (last_step) begin
               r_in   = '0;
               cnt_in = '0;
               unique case (state_ff)
                  ST_REDUCE: begin
                     base_in = unit_res;
                     if (exp_ff[0]) begin
                        state_in  = ST_MUL;
                        mplier_in = acc_ff;
                     end else begin
                        state_in  = ST_SQR;
                        mplier_in = unit_res;
                     end
                  end
                  ST_MUL: begin
                     acc_in = unit_res;
                     if (exp_shift == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in  = ST_SQR;
                        mplier_in = base_ff;
                     end
                  end
                  default: begin
                     base_in = unit_res;
                     exp_in  = exp_shift;
                     if (exp_shift[0]) begin
                        state_in  = ST_MUL;
                        mplier_in = acc_ff;
                     end else begin
                        state_in  = ST_SQR;
                        mplier_in = unit_res;
                     end
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mod_ff       <= modexp_pkg::MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff        <= r_in;
      mplier_ff   <= mplier_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(modexp_pkg::RSP_DATA_W - FW){1'b0}}, rsp_data_ff};

`ifndef SYNTHESIS
   // a zero exponent goes straight to the result with a value of one
   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_exp == '0) |=> (state_ff == ST_DONE && acc_ff == FW'(1)))
      else $error("zero exponent did not yield one");

   // the bit counter is back at zero whenever no product is in flight
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> (cnt_ff == '0))
      else $error("bit counter left running outside a product");

   // a new result beat only appears from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |-> ($past(state_ff) == ST_DONE))
      else $error("result beat raised outside the done state");
`endif

endmodule
